[rtl/frss_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// frss_pkg
// Types and constants shared by the flash record save sequencer modules.
// ----------------------------------------------------------------------------
package frss_pkg;

  // Fixed record header, word 0 of every saved record
  localparam logic [31:0] HEADER_WORD = 32'h5042_4D32;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITES_ENABLED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_TIMEOUT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_TIMEOUT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_SECTOR   = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration reset values
  localparam logic [15:0] ERASE_TIMEOUT_RST  = 16'd1000;
  localparam logic [15:0] PROG_TIMEOUT_RST   = 16'd100;
  localparam logic [15:0] VERIFY_TIMEOUT_RST = 16'd20;

  // Flash commands issued with each result
  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_UNLOCK  = 3'd1,
    CMD_ERASE   = 3'd2,
    CMD_PGMODE  = 3'd3,
    CMD_PROGRAM = 3'd4,
    CMD_LOCK    = 3'd5,
    CMD_ABORT   = 3'd6
  } cmd_t;

  // Failure reasons
  typedef enum logic [2:0] {
    FAIL_NONE     = 3'd0,
    FAIL_TIMEOUT  = 3'd1,
    FAIL_HW       = 3'd2,
    FAIL_MISMATCH = 3'd3,
    FAIL_PHASE    = 3'd4
  } fail_t;

  // Save sequence phases, one-hot
  typedef enum logic [14:0] {
    PH_IDLE       = 15'b000_0000_0000_0001,
    PH_PREP       = 15'b000_0000_0000_0010,
    PH_UNLOCK     = 15'b000_0000_0000_0100,
    PH_ERASE      = 15'b000_0000_0000_1000,
    PH_ERASE_WAIT = 15'b000_0000_0001_0000,
    PH_PROG0      = 15'b000_0000_0010_0000,
    PH_PWAIT0     = 15'b000_0000_0100_0000,
    PH_PROG1      = 15'b000_0000_1000_0000,
    PH_PWAIT1     = 15'b000_0001_0000_0000,
    PH_PROG2      = 15'b000_0010_0000_0000,
    PH_PWAIT2     = 15'b000_0100_0000_0000,
    PH_PROG3      = 15'b000_1000_0000_0000,
    PH_PWAIT3     = 15'b001_0000_0000_0000,
    PH_LOCK       = 15'b010_0000_0000_0000,
    PH_VERIFY     = 15'b100_0000_0000_0000
  } phase_t;

  // Phase number reported for a corrupted phase register
  localparam logic [3:0] PHASE_NUM_BAD = 4'd15;

  // Configuration registers as seen by the sequencer
  typedef struct packed {
    logic        writes_enabled;
    logic [15:0] erase_timeout_ms;
    logic [15:0] program_timeout_ms;
    logic [15:0] verify_timeout_ms;
    logic [3:0]  erase_sector;
  } cfg_t;

  // One input transaction
  typedef struct packed {
    logic        func;
    logic [31:0] now_ms;
    logic [15:0] tempo;
    logic [7:0]  preset_number;
    logic [7:0]  bank_number;
    logic        flash_busy;
    logic        flash_error;
    logic [31:0] read_header;
    logic [31:0] read_tempo;
    logic [31:0] read_preset;
    logic [31:0] read_bank;
  } item_t;

  // One result transaction
  typedef struct packed {
    cmd_t        command;
    logic [1:0]  word_index;
    logic [31:0] word_data;
    logic        is_busy;
    logic        last_ok;
    fail_t       fail_code;
    logic [3:0]  phase_now;
    logic [31:0] timeout_count;
    logic [31:0] mismatch_count;
  } result_t;

  // Phase number as seen by software
  function automatic logic [3:0] phase_num(input phase_t ph);
    logic [3:0] n;
    unique case (ph)
      PH_IDLE:       n = 4'd0;
      PH_PREP:       n = 4'd1;
      PH_UNLOCK:     n = 4'd2;
      PH_ERASE:      n = 4'd3;
      PH_ERASE_WAIT: n = 4'd4;
      PH_PROG0:      n = 4'd5;
      PH_PWAIT0:     n = 4'd6;
      PH_PROG1:      n = 4'd7;
      PH_PWAIT1:     n = 4'd8;
      PH_PROG2:      n = 4'd9;
      PH_PWAIT2:     n = 4'd10;
      PH_PROG3:      n = 4'd11;
      PH_PWAIT3:     n = 4'd12;
      PH_LOCK:       n = 4'd13;
      PH_VERIFY:     n = 4'd14;
      default:       n = PHASE_NUM_BAD;
    endcase
    return n;
  endfunction

endpackage : frss_pkg
`default_nettype wire

[rtl/flash_record_save_sequencer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// flash_record_save_sequencer
// Saves a four-word record to flash through an erase, program, verify
// sequence, one phase per service transaction.
// ----------------------------------------------------------------------------
// Every input transaction yields exactly one result transaction. The block
// takes one transaction per clock while the result channel is not stalled.
// The path runs through an input register, the phase-step logic (a 32-bit
// elapsed-time subtract and compare plus the read-back compare), then the
// result register. The input register can take one new transaction while
// a result waits at the output. Configuration registers may only be
// changed while no transaction is in flight; writes are taken at once.
// ----------------------------------------------------------------------------
module flash_record_save_sequencer #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [frss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [frss_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic                             in_func,
  input  wire logic [31:0]                      in_now_ms,
  input  wire logic [15:0]                      in_tempo,
  input  wire logic [7:0]                       in_preset_number,
  input  wire logic [7:0]                       in_bank_number,
  input  wire logic                             in_flash_busy,
  input  wire logic                             in_flash_error,
  input  wire logic [31:0]                      in_read_header,
  input  wire logic [31:0]                      in_read_tempo,
  input  wire logic [31:0]                      in_read_preset,
  input  wire logic [31:0]                      in_read_bank,
  // result channel
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic [2:0]                       out_command,
  output      logic [1:0]                       out_word_index,
  output      logic [31:0]                      out_word_data,
  output      logic                             out_is_busy,
  output      logic                             out_last_ok,
  output      logic [2:0]                       out_fail_code,
  output      logic [3:0]                       out_phase_now,
  output      logic [31:0]                      out_timeout_count,
  output      logic [31:0]                      out_mismatch_count
);
  import frss_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   item_r;
  logic    item_valid_r, item_valid_nxt;
  logic    step_en;
  result_t step_res;
  result_t res_r;
  logic    res_valid_r, res_valid_nxt;

  // Configuration registers
  frss_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Pack the incoming transaction
  always_comb begin
    in_item.func          = in_func;
    in_item.now_ms        = in_now_ms;
    in_item.tempo         = in_tempo;
    in_item.preset_number = in_preset_number;
    in_item.bank_number   = in_bank_number;
    in_item.flash_busy    = in_flash_busy;
    in_item.flash_error   = in_flash_error;
    in_item.read_header   = in_read_header;
    in_item.read_tempo    = in_read_tempo;
    in_item.read_preset   = in_read_preset;
    in_item.read_bank     = in_read_bank;
  end

  // Handshake: the step fires when the result register is free
  assign step_en        = item_valid_r && (!res_valid_r || out_ready);
  assign in_ready       = !item_valid_r || step_en;
  assign item_valid_nxt = in_valid || (item_valid_r && !step_en);
  assign res_valid_nxt  = step_en || (res_valid_r && !out_ready);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  // Sequencer state and step logic
  frss_core #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item    (item_r),
    .step_en (step_en),
    .res     (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= step_res;
    end
  end

  assign out_valid          = res_valid_r;
  assign out_command        = res_r.command;
  assign out_word_index     = res_r.word_index;
  assign out_word_data      = res_r.word_data;
  assign out_is_busy        = res_r.is_busy;
  assign out_last_ok        = res_r.last_ok;
  assign out_fail_code      = res_r.fail_code;
  assign out_phase_now      = res_r.phase_now;
  assign out_timeout_count  = res_r.timeout_count;
  assign out_mismatch_count = res_r.mismatch_count;

  // A save in progress always sits outside idle, and idle means not busy
  a_busy_phase : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_busy == (out_phase_now != 4'd0)))
    else $error("busy flag and phase disagree");

  // Success never carries a failure reason
  a_ok_reason : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_ok) |-> (out_fail_code == FAIL_NONE))
    else $error("success reported with a failure reason");

  // Program commands are only issued during a running save
  a_prog_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_command == CMD_PROGRAM) |-> out_is_busy)
    else $error("program command outside a save");

  // An abort always leaves the block idle with a reason recorded
  a_abort_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_command == CMD_ABORT)
      |-> (!out_is_busy && !out_last_ok && out_fail_code != FAIL_NONE))
    else $error("abort without failure state");

  // Word index only moves with a program command
  a_widx_prog : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word_index != 2'd0) |-> (out_command == CMD_PROGRAM))
    else $error("word index set without program command");

endmodule : flash_record_save_sequencer
`default_nettype wire

[rtl/frss_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// frss_cfg
// Configuration register file: write-only, one register per index.
// ----------------------------------------------------------------------------
module frss_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [frss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [frss_pkg::CFG_DATA_W-1:0]  cfg_data,
  output frss_pkg::cfg_t                        cfg
);
  import frss_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WRITES_ENABLED: cfg_nxt.writes_enabled     = cfg_data[0];
        CFG_ERASE_TIMEOUT:  cfg_nxt.erase_timeout_ms   = cfg_data;
        CFG_PROG_TIMEOUT:   cfg_nxt.program_timeout_ms = cfg_data;
        CFG_VERIFY_TIMEOUT: cfg_nxt.verify_timeout_ms  = cfg_data;
        CFG_ERASE_SECTOR:   cfg_nxt.erase_sector       = cfg_data[3:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.writes_enabled     <= 1'b1;
      cfg_r.erase_timeout_ms   <= ERASE_TIMEOUT_RST;
      cfg_r.program_timeout_ms <= PROG_TIMEOUT_RST;
      cfg_r.verify_timeout_ms  <= VERIFY_TIMEOUT_RST;
      cfg_r.erase_sector       <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule : frss_cfg
`default_nettype wire

[rtl/frss_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// frss_core
// Save sequencer state and the one-phase step logic for each transaction.
// ----------------------------------------------------------------------------
module frss_core #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire frss_pkg::cfg_t   cfg,
  input  wire frss_pkg::item_t  item,
  input  wire logic             step_en,
  output frss_pkg::result_t     res
);
  import frss_pkg::*;

  phase_t                   phase_r, phase_nxt;
  logic                     busy_r, busy_nxt;
  logic                     ok_r, ok_nxt;
  fail_t                    reason_r, reason_nxt;
  logic [31:0]              start_r, start_nxt;
  logic [COUNTER_WIDTH-1:0] tmo_r, tmo_nxt;
  logic [COUNTER_WIDTH-1:0] mis_r, mis_nxt;
  logic [15:0]              tempo_r, tempo_nxt;
  logic [7:0]               preset_r, preset_nxt;
  logic [7:0]               bank_r, bank_nxt;

  logic [31:0] elapsed;
  logic [15:0] limit;
  logic        expired;
  logic        verify_ok;
  logic        fail_now;
  fail_t       fail_sel;
  cmd_t        cmd;
  logic [1:0]  widx;
  logic [31:0] wdata;

  // Timeout of the current wait phase (wrap-safe elapsed time)
  always_comb begin
    unique case (phase_r)
      PH_ERASE_WAIT: limit = cfg.erase_timeout_ms;
      PH_VERIFY:     limit = cfg.verify_timeout_ms;
      default:       limit = cfg.program_timeout_ms;
    endcase
  end

  assign elapsed = item.now_ms - start_r;
  assign expired = elapsed >= 32'(limit);

  // Read-back compare against the latched record
  assign verify_ok = (item.read_header == HEADER_WORD)
                   && (item.read_tempo  == 32'(tempo_r))
                   && (item.read_preset == 32'(preset_r))
                   && (item.read_bank   == 32'(bank_r));

  // One sequencing step
  always_comb begin
    phase_nxt  = phase_r;
    busy_nxt   = busy_r;
    ok_nxt     = ok_r;
    reason_nxt = reason_r;
    start_nxt  = start_r;
    tmo_nxt    = tmo_r;
    mis_nxt    = mis_r;
    tempo_nxt  = tempo_r;
    preset_nxt = preset_r;
    bank_nxt   = bank_r;
    cmd        = CMD_NONE;
    widx       = '0;
    wdata      = '0;
    fail_now   = 1'b0;
    fail_sel   = FAIL_NONE;

    if (!item.func) begin
      // save request, dropped while a save runs
      if (!busy_r) begin
        tempo_nxt  = item.tempo;
        preset_nxt = item.preset_number;
        bank_nxt   = item.bank_number;
        reason_nxt = FAIL_NONE;
        start_nxt  = item.now_ms;
        if (!cfg.writes_enabled) begin
          busy_nxt  = 1'b0;
          ok_nxt    = 1'b1;
          phase_nxt = PH_IDLE;
        end else begin
          busy_nxt  = 1'b1;
          ok_nxt    = 1'b0;
          phase_nxt = PH_PREP;
        end
      end
    end else if (cfg.writes_enabled && busy_r) begin
      // service pass
      unique case (phase_r)
        PH_PREP: begin
          phase_nxt = PH_UNLOCK;
          start_nxt = item.now_ms;
        end
        PH_UNLOCK: begin
          cmd       = CMD_UNLOCK;
          phase_nxt = PH_ERASE;
          start_nxt = item.now_ms;
        end
        PH_ERASE: begin
          cmd       = CMD_ERASE;
          wdata     = 32'(cfg.erase_sector);
          phase_nxt = PH_ERASE_WAIT;
          start_nxt = item.now_ms;
        end
        PH_ERASE_WAIT: begin
          if (expired) begin
            fail_now = 1'b1;
            fail_sel = FAIL_TIMEOUT;
          end else if (!item.flash_busy) begin
            if (item.flash_error) begin
              fail_now = 1'b1;
              fail_sel = FAIL_HW;
            end else begin
              cmd       = CMD_PGMODE;
              phase_nxt = PH_PROG0;
              start_nxt = item.now_ms;
            end
          end
        end
        PH_PROG0: begin
          cmd       = CMD_PROGRAM;
          widx      = 2'd0;
          wdata     = HEADER_WORD;
          phase_nxt = PH_PWAIT0;
          start_nxt = item.now_ms;
        end
        PH_PROG1: begin
          cmd       = CMD_PROGRAM;
          widx      = 2'd1;
          wdata     = 32'(tempo_r);
          phase_nxt = PH_PWAIT1;
          start_nxt = item.now_ms;
        end
        PH_PROG2: begin
          cmd       = CMD_PROGRAM;
          widx      = 2'd2;
          wdata     = 32'(preset_r);
          phase_nxt = PH_PWAIT2;
          start_nxt = item.now_ms;
        end
        PH_PROG3: begin
          cmd       = CMD_PROGRAM;
          widx      = 2'd3;
          wdata     = 32'(bank_r);
          phase_nxt = PH_PWAIT3;
          start_nxt = item.now_ms;
        end
        PH_PWAIT0, PH_PWAIT1, PH_PWAIT2, PH_PWAIT3: begin
          if (expired) begin
            fail_now = 1'b1;
            fail_sel = FAIL_TIMEOUT;
          end else if (!item.flash_busy) begin
            if (item.flash_error) begin
              fail_now = 1'b1;
              fail_sel = FAIL_HW;
            end else begin
              start_nxt = item.now_ms;
              unique case (phase_r)
                PH_PWAIT0: phase_nxt = PH_PROG1;
                PH_PWAIT1: phase_nxt = PH_PROG2;
                PH_PWAIT2: phase_nxt = PH_PROG3;
                default:   phase_nxt = PH_LOCK;
              endcase
            end
          end
        end
        PH_LOCK: begin
          cmd       = CMD_LOCK;
          phase_nxt = PH_VERIFY;
          start_nxt = item.now_ms;
        end
        PH_VERIFY: begin
          if (expired) begin
            fail_now = 1'b1;
            fail_sel = FAIL_TIMEOUT;
          end else if (!verify_ok) begin
            fail_now = 1'b1;
            fail_sel = FAIL_MISMATCH;
          end else begin
            // flash already locked, nothing to issue
            busy_nxt   = 1'b0;
            ok_nxt     = 1'b1;
            reason_nxt = FAIL_NONE;
            phase_nxt  = PH_IDLE;
            start_nxt  = item.now_ms;
          end
        end
        default: begin
          // busy in idle or a corrupted phase
          fail_now = 1'b1;
          fail_sel = FAIL_PHASE;
        end
      endcase
    end

    // Abort: issue the abort command, record the reason, bump the saturating timeout or mismatch counter
    if (fail_now) begin
      cmd        = CMD_ABORT;
      widx       = '0;
      wdata      = '0;
      busy_nxt   = 1'b0;
      ok_nxt     = 1'b0;
      reason_nxt = fail_sel;
      phase_nxt  = PH_IDLE;
      start_nxt  = item.now_ms;
      if (fail_sel == FAIL_TIMEOUT && tmo_r != '1) begin
        tmo_nxt = tmo_r + 1'b1;
      end
      if (fail_sel == FAIL_MISMATCH && mis_r != '1) begin
        mis_nxt = mis_r + 1'b1;
      end
    end
  end

  // State registers, updated once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      busy_r   <= 1'b0;
      ok_r     <= 1'b1;
      reason_r <= FAIL_NONE;
      start_r  <= '0;
      tmo_r    <= '0;
      mis_r    <= '0;
      tempo_r  <= '0;
      preset_r <= '0;
      bank_r   <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      busy_r   <= busy_nxt;
      ok_r     <= ok_nxt;
      reason_r <= reason_nxt;
      start_r  <= start_nxt;
      tmo_r    <= tmo_nxt;
      mis_r    <= mis_nxt;
      tempo_r  <= tempo_nxt;
      preset_r <= preset_nxt;
      bank_r   <= bank_nxt;
    end
  end

  // Result reports the state after the step
  always_comb begin
    res.command        = cmd;
    res.word_index     = widx;
    res.word_data      = wdata;
    res.is_busy        = busy_nxt;
    res.last_ok        = ok_nxt;
    res.fail_code      = reason_nxt;
    res.phase_now      = phase_num(phase_nxt);
    res.timeout_count  = 32'(tmo_nxt);
    res.mismatch_count = 32'(mis_nxt);
  end

endmodule : frss_core
`default_nettype wire

[tb/sv/tb_flash_record_save_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flash_record_save_sequencer
// Self-checking bench for the flash record save sequencer. Save requests and
// service passes are driven over a valid/ready channel. A behavioural copy of
// the erase/program/verify sequence predicts every result transaction, and
// each result is compared field by field. The run covers directed corner
// cases, then segments of random save runs under changing register settings
// and idling patterns.
// ----------------------------------------------------------------------------
module tb_flash_record_save_sequencer;
  import frss_pkg::*;

  // Phase numbers as reported on out_phase_now
  localparam logic [3:0] PN_IDLE       = 4'd0;
  localparam logic [3:0] PN_PREP       = 4'd1;
  localparam logic [3:0] PN_UNLOCK     = 4'd2;
  localparam logic [3:0] PN_ERASE      = 4'd3;
  localparam logic [3:0] PN_ERASE_WAIT = 4'd4;
  localparam logic [3:0] PN_PROG0      = 4'd5;
  localparam logic [3:0] PN_PWAIT0     = 4'd6;
  localparam logic [3:0] PN_PROG1      = 4'd7;
  localparam logic [3:0] PN_PWAIT1     = 4'd8;
  localparam logic [3:0] PN_PROG2      = 4'd9;
  localparam logic [3:0] PN_PWAIT2     = 4'd10;
  localparam logic [3:0] PN_PROG3      = 4'd11;
  localparam logic [3:0] PN_PWAIT3     = 4'd12;
  localparam logic [3:0] PN_LOCK       = 4'd13;
  localparam logic [3:0] PN_VERIFY     = 4'd14;

  // Transaction kinds
  localparam logic FUNC_SAVE    = 1'b0;
  localparam logic FUNC_SERVICE = 1'b1;

  localparam int unsigned N_SEGS       = 9;
  localparam int unsigned SEG_ITEMS    = 150;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT  = 200_000;

  // DUT signals
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_func = 1'b0;
  logic [31:0] in_now_ms = '0;
  logic [15:0] in_tempo = '0;
  logic [7:0]  in_preset_number = '0;
  logic [7:0]  in_bank_number = '0;
  logic        in_flash_busy = 1'b0;
  logic        in_flash_error = 1'b0;
  logic [31:0] in_read_header = '0;
  logic [31:0] in_read_tempo = '0;
  logic [31:0] in_read_preset = '0;
  logic [31:0] in_read_bank = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_command;
  logic [1:0]  out_word_index;
  logic [31:0] out_word_data;
  logic        out_is_busy;
  logic        out_last_ok;
  logic [2:0]  out_fail_code;
  logic [3:0]  out_phase_now;
  logic [31:0] out_timeout_count;
  logic [31:0] out_mismatch_count;

  // Stimulus and scoreboard
  item_t       save_reqs_q[$];
  result_t     steps_due_q[$];
  item_t       on_wire;
  bit          req_taken = 1'b0;
  int unsigned items_queued = 0;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;

  // Record and millisecond tick used when building transactions
  logic [31:0] ms_now = '0;
  logic [15:0] rec_tempo = '0;
  logic [7:0]  rec_preset = '0;
  logic [7:0]  rec_bank = '0;

  // Register shadow, reset values
  logic        cfg_wr_en = 1'b1;
  logic [15:0] cfg_erase_to = ERASE_TIMEOUT_RST;
  logic [15:0] cfg_prog_to = PROG_TIMEOUT_RST;
  logic [15:0] cfg_verify_to = VERIFY_TIMEOUT_RST;
  logic [3:0]  cfg_sector = 4'd0;

  // Predicted sequencer state, reset values
  logic [3:0]  sv_phase = PN_IDLE;
  logic        sv_busy = 1'b0;
  logic        sv_ok = 1'b1;
  fail_t       sv_reason = FAIL_NONE;
  logic [31:0] sv_start = '0;
  logic [31:0] sv_timeouts = '0;
  logic [31:0] sv_mismatches = '0;
  logic [15:0] sv_tempo = '0;
  logic [7:0]  sv_preset = '0;
  logic [7:0]  sv_bank = '0;

  flash_record_save_sequencer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_now_ms          (in_now_ms),
    .in_tempo           (in_tempo),
    .in_preset_number   (in_preset_number),
    .in_bank_number     (in_bank_number),
    .in_flash_busy      (in_flash_busy),
    .in_flash_error     (in_flash_error),
    .in_read_header     (in_read_header),
    .in_read_tempo      (in_read_tempo),
    .in_read_preset     (in_read_preset),
    .in_read_bank       (in_read_bank),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_command        (out_command),
    .out_word_index     (out_word_index),
    .out_word_data      (out_word_data),
    .out_is_busy        (out_is_busy),
    .out_last_ok        (out_last_ok),
    .out_fail_code      (out_fail_code),
    .out_phase_now      (out_phase_now),
    .out_timeout_count  (out_timeout_count),
    .out_mismatch_count (out_mismatch_count)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Sequence prediction
  // --------------------------------------------------------------------------
  function automatic void enter_phase(logic [3:0] ph, logic [31:0] now);
    sv_phase = ph;
    sv_start = now;
  endfunction

  // Abort the save, issue the abort command and keep the reason; counters saturate
  function automatic cmd_t abort_save(fail_t why, logic [31:0] now);
    sv_busy = 1'b0;
    sv_ok = 1'b0;
    sv_reason = why;
    enter_phase(PN_IDLE, now);
    if (why == FAIL_TIMEOUT && sv_timeouts != '1) sv_timeouts++;
    if (why == FAIL_MISMATCH && sv_mismatches != '1) sv_mismatches++;
    return CMD_ABORT;
  endfunction

  function automatic result_t predict_save_step(item_t it);
    result_t     r;
    logic [31:0] elapsed;
    r = '0;
    r.command = CMD_NONE;
    r.fail_code = FAIL_NONE;
    // wrap-safe time spent in the current phase
    elapsed = it.now_ms - sv_start;
    if (it.func == FUNC_SAVE) begin
      // a save while busy is dropped
      if (!sv_busy) begin
        sv_tempo = it.tempo;
        sv_preset = it.preset_number;
        sv_bank = it.bank_number;
        sv_ok = 1'b0;
        sv_reason = FAIL_NONE;
        sv_start = it.now_ms;
        if (!cfg_wr_en) begin
          sv_busy = 1'b0;
          sv_ok = 1'b1;
          sv_phase = PN_IDLE;
        end else begin
          sv_busy = 1'b1;
          enter_phase(PN_PREP, it.now_ms);
        end
      end
    end else if (cfg_wr_en && sv_busy) begin
      case (sv_phase)
        PN_PREP: enter_phase(PN_UNLOCK, it.now_ms);
        PN_UNLOCK: begin
          r.command = CMD_UNLOCK;
          enter_phase(PN_ERASE, it.now_ms);
        end
        PN_ERASE: begin
          r.command = CMD_ERASE;
          r.word_data = {28'd0, cfg_sector};
          enter_phase(PN_ERASE_WAIT, it.now_ms);
        end
        PN_ERASE_WAIT: begin
          // timeout takes priority over the busy flag
          if (elapsed >= {16'd0, cfg_erase_to}) begin
            r.command = abort_save(FAIL_TIMEOUT, it.now_ms);
          end else if (!it.flash_busy) begin
            if (it.flash_error) begin
              r.command = abort_save(FAIL_HW, it.now_ms);
            end else begin
              r.command = CMD_PGMODE;
              enter_phase(PN_PROG0, it.now_ms);
            end
          end
        end
        PN_PROG0, PN_PROG1, PN_PROG2, PN_PROG3: begin
          r.command = CMD_PROGRAM;
          r.word_index = 2'((sv_phase - PN_PROG0) >> 1);
          case (r.word_index)
            2'd0:    r.word_data = HEADER_WORD;
            2'd1:    r.word_data = {16'd0, sv_tempo};
            2'd2:    r.word_data = {24'd0, sv_preset};
            default: r.word_data = {24'd0, sv_bank};
          endcase
          enter_phase(4'(sv_phase + 4'd1), it.now_ms);
        end
        PN_PWAIT0, PN_PWAIT1, PN_PWAIT2, PN_PWAIT3: begin
          if (elapsed >= {16'd0, cfg_prog_to}) begin
            r.command = abort_save(FAIL_TIMEOUT, it.now_ms);
          end else if (!it.flash_busy) begin
            if (it.flash_error) r.command = abort_save(FAIL_HW, it.now_ms);
            else enter_phase(4'(sv_phase + 4'd1), it.now_ms);
          end
        end
        PN_LOCK: begin
          r.command = CMD_LOCK;
          enter_phase(PN_VERIFY, it.now_ms);
        end
        PN_VERIFY: begin
          if (elapsed >= {16'd0, cfg_verify_to}) begin
            r.command = abort_save(FAIL_TIMEOUT, it.now_ms);
          end else if (it.read_header != HEADER_WORD
                       || it.read_tempo != {16'd0, sv_tempo}
                       || it.read_preset != {24'd0, sv_preset}
                       || it.read_bank != {24'd0, sv_bank}) begin
            r.command = abort_save(FAIL_MISMATCH, it.now_ms);
          end else begin
            // flash already locked, nothing to issue
            sv_busy = 1'b0;
            sv_ok = 1'b1;
            sv_reason = FAIL_NONE;
            enter_phase(PN_IDLE, it.now_ms);
          end
        end
        default: r.command = abort_save(FAIL_PHASE, it.now_ms);
      endcase
    end
    r.is_busy = sv_busy;
    r.last_ok = sv_ok;
    r.fail_code = sv_reason;
    r.phase_now = sv_phase;
    r.timeout_count = sv_timeouts;
    r.mismatch_count = sv_mismatches;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Transaction builders
  // --------------------------------------------------------------------------
  function automatic void queue_item(item_t it);
    save_reqs_q.push_back(it);
    items_queued++;
  endfunction

  // Save request; latch marks the record the read-back should later match
  function automatic item_t save_req(bit latch, logic [15:0] t, logic [7:0] p,
                                     logic [7:0] b);
    item_t it;
    it.func = FUNC_SAVE;
    it.now_ms = ms_now;
    it.tempo = t;
    it.preset_number = p;
    it.bank_number = b;
    it.flash_busy = 1'($urandom);
    it.flash_error = 1'($urandom);
    it.read_header = $urandom;
    it.read_tempo = $urandom;
    it.read_preset = $urandom;
    it.read_bank = $urandom;
    if (latch) begin
      rec_tempo = t;
      rec_preset = p;
      rec_bank = b;
    end
    return it;
  endfunction

  // Service pass; read-back matches the latched record unless corrupted
  function automatic item_t service_pass(bit fbusy, bit ferr, bit corrupt);
    item_t it;
    it.func = FUNC_SERVICE;
    it.now_ms = ms_now;
    it.tempo = 16'($urandom);
    it.preset_number = 8'($urandom);
    it.bank_number = 8'($urandom);
    it.flash_busy = fbusy;
    it.flash_error = ferr;
    it.read_header = HEADER_WORD;
    it.read_tempo = {16'd0, rec_tempo};
    it.read_preset = {24'd0, rec_preset};
    it.read_bank = {24'd0, rec_bank};
    if (corrupt) begin
      case ($urandom_range(3))
        0:       it.read_header ^= 32'd1 << $urandom_range(31);
        1:       it.read_tempo ^= 32'd1 << $urandom_range(31);
        2:       it.read_preset ^= 32'd1 << $urandom_range(31);
        default: it.read_bank ^= 32'd1 << $urandom_range(31);
      endcase
    end
    return it;
  endfunction

  // One save followed by enough service passes to usually run it through
  task automatic queue_save_run();
    int unsigned n_passes;
    int unsigned roll;
    n_passes = 14 + $urandom_range(0, 6);
    if ($urandom_range(7) == 0) ms_now = $urandom;
    queue_item(save_req(1'b1, 16'($urandom), 8'($urandom), 8'($urandom)));
    repeat (n_passes) begin
      roll = $urandom_range(99);
      if (roll < 85) ms_now += $urandom_range(0, 3);
      else if (roll < 97) ms_now += $urandom_range(4, 300);
      else ms_now += $urandom;
      if ($urandom_range(24) == 0)
        queue_item(save_req(1'b0, 16'($urandom), 8'($urandom), 8'($urandom)));
      queue_item(service_pass($urandom_range(3) == 0, $urandom_range(29) == 0,
                              $urandom_range(7) == 0));
    end
  endtask

  function automatic logic [15:0] pick_timeout();
    case ($urandom_range(5))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3, 4:    return 16'($urandom_range(2, 40));
      default: return 16'($urandom);
    endcase
  endfunction

  // Wait until nothing is queued, offered or outstanding
  task automatic wait_idle();
    do @(posedge clk);
    while (save_reqs_q.size() != 0 || in_valid || steps_due_q.size() != 0);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_WRITES_ENABLED: cfg_wr_en = val[0];
      CFG_ERASE_TIMEOUT:  cfg_erase_to = val;
      CFG_PROG_TIMEOUT:   cfg_prog_to = val;
      CFG_VERIFY_TIMEOUT: cfg_verify_to = val;
      CFG_ERASE_SECTOR:   cfg_sector = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_cfg(logic we, logic [15:0] erase_to, logic [15:0] prog_to,
                           logic [15:0] verify_to, logic [3:0] sector);
    cfg_write(CFG_WRITES_ENABLED, {15'd0, we});
    cfg_write(CFG_ERASE_TIMEOUT, erase_to);
    cfg_write(CFG_PROG_TIMEOUT, prog_to);
    cfg_write(CFG_VERIFY_TIMEOUT, verify_to);
    cfg_write(CFG_ERASE_SECTOR, {12'd0, sector});
  endtask

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, fname, want, got);
      fault_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Input driver: a new transaction goes out only after the last one was taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : take_requests
    if (rst_n && in_valid && in_ready) begin
      steps_due_q.push_back(predict_save_step(on_wire));
      req_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : drive_requests
    if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (save_reqs_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        on_wire = save_reqs_q.pop_front();
        in_valid <= 1'b1;
        in_func <= on_wire.func;
        in_now_ms <= on_wire.now_ms;
        in_tempo <= on_wire.tempo;
        in_preset_number <= on_wire.preset_number;
        in_bank_number <= on_wire.bank_number;
        in_flash_busy <= on_wire.flash_busy;
        in_flash_error <= on_wire.flash_error;
        in_read_header <= on_wire.read_header;
        in_read_tempo <= on_wire.read_tempo;
        in_read_preset <= on_wire.read_preset;
        in_read_bank <= on_wire.read_bank;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure plus an occasional long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : result_ready
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (steps_due_q.size() == 0) begin
        $display("%0t ns: unexpected result transaction, expected none, actual command 0x%0h",
                 $time, out_command);
        fault_count++;
      end else begin
        want = steps_due_q.pop_front();
        check_field("command", want.command, out_command);
        check_field("word_index", want.word_index, out_word_index);
        check_field("word_data", want.word_data, out_word_data);
        check_field("is_busy", want.is_busy, out_is_busy);
        check_field("last_ok", want.last_ok, out_last_ok);
        check_field("fail_code", want.fail_code, out_fail_code);
        check_field("phase_now", want.phase_now, out_phase_now);
        check_field("timeout_count", want.timeout_count, out_timeout_count);
        check_field("mismatch_count", want.mismatch_count, out_mismatch_count);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : run_test
    item_t       it;
    int unsigned seg_start;
    send_idle_pct = 28;
    recv_idle_pct = 73;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: full save at reset settings, crossing the tick wrap
    ms_now = 32'hFFFF_FFFE;
    queue_item(service_pass(1'b0, 1'b0, 1'b0));   // idle: nothing to do
    queue_item(save_req(1'b1, 16'hFFFF, 8'hFF, 8'hFF));
    queue_item(save_req(1'b0, 16'h0000, 8'h00, 8'h00));   // dropped, busy
    for (int i = 0; i < 15; i++) begin
      ms_now += 1;
      // one busy wait on the erase, verify passes at the end
      queue_item(service_pass(i == 3, 1'b0, 1'b0));
    end
    // Save left half done while writes are switched off
    queue_item(save_req(1'b1, 16'h0000, 8'h00, 8'h00));
    ms_now += 1;
    queue_item(service_pass(1'b0, 1'b0, 1'b0));
    wait_idle();
    cfg_write(CFG_WRITES_ENABLED, 16'd0);
    queue_item(service_pass(1'b0, 1'b0, 1'b0));   // held, no progress
    queue_item(save_req(1'b0, 16'h1234, 8'h56, 8'h78));   // still busy
    wait_idle();

    // Random segments, each under its own register setting
    for (int seg = 0; seg < N_SEGS; seg++) begin
      case (seg)
        0:       apply_cfg(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
        1:       apply_cfg(1'b1, 16'd0, 16'd0, 16'd0, 4'h0);
        2:       apply_cfg(1'b0, 16'd1, 16'd1, 16'd1, 4'h5);
        default: apply_cfg($urandom_range(5) != 0, pick_timeout(), pick_timeout(),
                           pick_timeout(), 4'($urandom));
      endcase
      if (seg == 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 28;
      end else if (seg == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long result stall while the sender keeps offering
      if (seg == 6 || seg == 8) hold_req = 1'b1;
      seg_start = items_queued;
      while (items_queued - seg_start < SEG_ITEMS) begin
        if ($urandom_range(9) == 0) begin
          it = save_req(1'b0, 16'($urandom), 8'($urandom), 8'($urandom));
          it.func = 1'($urandom);
          it.now_ms = $urandom;
          queue_item(it);
        end else begin
          queue_save_run();
        end
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && steps_due_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
